[hdl/mip_pkg.sv]
// Package for the MIDI input event parser: status byte codes, event kinds,
// register indexes, the event record type and the data length table.
// No dependencies.
package mip_pkg;

  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_QFRAME      = 8'hF1;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_CLOCK       = 8'hF8;
  localparam logic [7:0] ST_START       = 8'hFA;
  localparam logic [7:0] ST_STOP        = 8'hFC;
  localparam logic [7:0] ST_SENSE       = 8'hFE;

  localparam logic [2:0] SYS_GROUP      = 3'b111;

  localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
  localparam logic [3:0] CMD_PITCH_BEND = 4'hE;

  localparam logic [3:0] KIND_VOICE       = 4'd0;
  localparam logic [3:0] KIND_TICK        = 4'd1;
  localparam logic [3:0] KIND_START       = 4'd2;
  localparam logic [3:0] KIND_STOP        = 4'd3;
  localparam logic [3:0] KIND_SENSE       = 4'd4;
  localparam logic [3:0] KIND_SYSEX_START = 4'd5;
  localparam logic [3:0] KIND_SYSEX_DATA  = 4'd6;
  localparam logic [3:0] KIND_SYSEX_END   = 4'd7;
  localparam logic [3:0] KIND_SYSEX_ABORT = 4'd8;
  localparam logic [3:0] KIND_QFRAME      = 4'd9;

  localparam logic [1:0] CFG_INPUT_ENABLED     = 2'd0;
  localparam logic [1:0] CFG_CLOCK_SOURCE      = 2'd1;
  localparam logic [1:0] CFG_TIMECODE_SOURCE   = 2'd2;
  localparam logic [1:0] CFG_NOTE_OFF_VELOCITY = 2'd3;

  localparam logic [6:0] NOTE_OFF_VEL_RESET = 7'd64;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  command;
    logic [3:0]  channel;
    logic [6:0]  first_value;
    logic [6:0]  second_value;
    logic [13:0] bend_value;
    logic [7:0]  raw_byte;
    logic        dropped_previous;
  } evt_t;

  // data bytes per voice command, indexed by status bits 6:4
  function automatic logic [1:0] msg_len(input logic [2:0] cmd);
    logic [1:0] len;
    case (cmd)
      3'd4, 3'd5: len = 2'd1;
      3'd7:       len = 2'd0;
      default:    len = 2'd2;
    endcase
    return len;
  endfunction

endpackage

[hdl/midi_input_event_parser.sv]
// MIDI input event parser: running status decode of received bytes into events.
// Depends on mip_pkg for codes, the event record and the length table.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   input   | in_valid, in_stall, in_data_byte    | byte in
//   result  | out_valid, out_stall, out_*         | event out
//   config  | cfg_wr_en, cfg_index, cfg_wr_data   | write only
//
// One byte per cycle while in_stall is low; the accepting edge writes its event
// into the output register, or into the skid register while the output is
// stalled; in_stall is high only while the skid register is full.
// Synchronous active-low reset clears running status, sysex flag; sets config.
module midi_input_event_parser
  import mip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wr_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [3:0]  out_command,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_first_value,
  output logic [6:0]  out_second_value,
  output logic [13:0] out_bend_value,
  output logic [7:0]  out_raw_byte,
  output logic        out_dropped_previous
);

  logic       input_enabled_r;
  logic       clock_source_r;
  logic       timecode_source_r;
  logic [6:0] note_off_vel_r;

  logic [7:0] running_status_r, running_status_nxt;
  logic       data_pending_r, data_pending_nxt;
  logic [6:0] first_data_r, first_data_nxt;
  logic       sysex_open_r, sysex_open_nxt;

  evt_t       out_evt_r;
  logic       out_valid_r;
  evt_t       skid_evt_r;
  logic       skid_valid_r;

  evt_t       evt;
  logic       evt_hit;
  logic       in_acc;
  logic       out_fire;
  logic [1:0] len;
  logic [6:0] v0, v1;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;
  assign len      = msg_len(running_status_r[6:4]);

  always_comb begin
    evt                = '0;
    evt_hit            = 1'b0;
    running_status_nxt = running_status_r;
    data_pending_nxt   = data_pending_r;
    first_data_nxt     = first_data_r;
    sysex_open_nxt     = sysex_open_r;
    v0                 = '0;
    v1                 = '0;
    if (input_enabled_r) begin
      if (in_data_byte >= ST_CLOCK) begin
        unique case (in_data_byte)
          ST_CLOCK: begin
            evt_hit  = clock_source_r;
            evt.kind = KIND_TICK;
          end
          ST_START: begin
            evt_hit  = clock_source_r;
            evt.kind = KIND_START;
          end
          ST_STOP: begin
            evt_hit  = clock_source_r;
            evt.kind = KIND_STOP;
          end
          ST_SENSE: begin
            evt_hit  = 1'b1;
            evt.kind = KIND_SENSE;
          end
          default: evt_hit = 1'b0;
        endcase
      end else if (in_data_byte[7]) begin
        running_status_nxt = in_data_byte;
        data_pending_nxt   = 1'b0;
        evt.raw_byte       = in_data_byte;
        if (in_data_byte == ST_SYSEX_START) begin
          sysex_open_nxt       = 1'b1;
          evt_hit              = 1'b1;
          evt.kind             = KIND_SYSEX_START;
          evt.dropped_previous = sysex_open_r;
        end else if (in_data_byte == ST_SYSEX_END) begin
          running_status_nxt = '0;
          sysex_open_nxt     = 1'b0;
          evt_hit            = sysex_open_r;
          evt.kind           = KIND_SYSEX_END;
        end else begin
          sysex_open_nxt = 1'b0;
          evt_hit        = sysex_open_r;
          evt.kind       = KIND_SYSEX_ABORT;
        end
      end else if (running_status_r[7] && running_status_r[6:4] != SYS_GROUP) begin
        if (!data_pending_r && len == 2'd2) begin
          first_data_nxt   = in_data_byte[6:0];
          data_pending_nxt = 1'b1;
        end else begin
          data_pending_nxt = 1'b0;
          if (len == 2'd1) begin
            v0 = in_data_byte[6:0];
          end else begin
            v0 = first_data_r;
            v1 = in_data_byte[6:0];
          end
          evt_hit     = 1'b1;
          evt.kind    = KIND_VOICE;
          evt.command = running_status_r[7:4];
          evt.channel = running_status_r[3:0];
          if (running_status_r[7:4] == CMD_NOTE_ON && v1 == '0) begin
            evt.command      = CMD_NOTE_OFF;
            evt.first_value  = v0;
            evt.second_value = note_off_vel_r;
          end else if (running_status_r[7:4] == CMD_PITCH_BEND) begin
            evt.bend_value = {v1, v0};
          end else begin
            evt.first_value  = v0;
            evt.second_value = v1;
          end
        end
      end else if (running_status_r == ST_SYSEX_START) begin
        evt_hit      = sysex_open_r;
        evt.kind     = KIND_SYSEX_DATA;
        evt.raw_byte = in_data_byte;
      end else if (running_status_r == ST_QFRAME) begin
        running_status_nxt = '0;
        evt_hit            = timecode_source_r;
        evt.kind           = KIND_QFRAME;
        evt.raw_byte       = in_data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_enabled_r   <= 1'b1;
      clock_source_r    <= 1'b0;
      timecode_source_r <= 1'b0;
      note_off_vel_r    <= NOTE_OFF_VEL_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_INPUT_ENABLED:     input_enabled_r   <= cfg_wr_data[0];
        CFG_CLOCK_SOURCE:      clock_source_r    <= cfg_wr_data[0];
        CFG_TIMECODE_SOURCE:   timecode_source_r <= cfg_wr_data[0];
        CFG_NOTE_OFF_VELOCITY: note_off_vel_r    <= cfg_wr_data;
        default:               input_enabled_r   <= input_enabled_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_status_r <= '0;
      data_pending_r   <= 1'b0;
      sysex_open_r     <= 1'b0;
    end else if (in_acc) begin
      running_status_r <= running_status_nxt;
      data_pending_r   <= data_pending_nxt;
      sysex_open_r     <= sysex_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      first_data_r <= first_data_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc && evt_hit) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_evt_r <= skid_evt_r;
      end
    end else if (in_acc && evt_hit) begin
      if (out_valid_r && !out_fire) begin
        skid_evt_r <= evt;
      end else begin
        out_evt_r <= evt;
      end
    end
  end

  assign in_stall             = skid_valid_r;
  assign out_valid            = out_valid_r;
  assign out_kind             = out_evt_r.kind;
  assign out_command          = out_evt_r.command;
  assign out_channel          = out_evt_r.channel;
  assign out_first_value      = out_evt_r.first_value;
  assign out_second_value     = out_evt_r.second_value;
  assign out_bend_value       = out_evt_r.bend_value;
  assign out_raw_byte         = out_evt_r.raw_byte;
  assign out_dropped_previous = out_evt_r.dropped_previous;

endmodule

[tb/tb.sv]
// Self-checking bench for midi_input_event_parser: drives MIDI byte streams and
// checks every event against an in-bench model of running status and sysex framing.
// Depends on mip_pkg and the parser RTL only.
module tb;
  import mip_pkg::*;

  localparam logic [3:0] CMD_PROGRAM  = 4'hC;
  localparam logic [3:0] CMD_PRESSURE = 4'hD;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_INPUT_ENABLED;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_kind;
  logic [3:0]  out_command;
  logic [3:0]  out_channel;
  logic [6:0]  out_first_value;
  logic [6:0]  out_second_value;
  logic [13:0] out_bend_value;
  logic [7:0]  out_raw_byte;
  logic        out_dropped_previous;

  midi_input_event_parser dut (.*);

  always #5 clk = ~clk;

  class event_scoreboard;
    bit         input_enabled = 1'b1;
    bit         clock_source = 1'b0;
    bit         timecode_source = 1'b0;
    logic [6:0] note_off_velocity = NOTE_OFF_VEL_RESET;
    logic [7:0] running_status = '0;
    logic [1:0] data_count = '0;
    logic [6:0] first_data;
    bit         sysex_open = 1'b0;
    evt_t       pending_events[$];
    int         errors = 0;

    function void set_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        CFG_INPUT_ENABLED:     input_enabled = val[0];
        CFG_CLOCK_SOURCE:      clock_source = val[0];
        CFG_TIMECODE_SOURCE:   timecode_source = val[0];
        CFG_NOTE_OFF_VELOCITY: note_off_velocity = val;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      evt_t       e;
      bit         fire;
      logic [3:0] cmd;
      logic [1:0] len;
      logic [6:0] v0;
      logic [6:0] v1;
      e = '0;
      fire = 1'b0;
      if (!input_enabled) return;
      if (b >= ST_CLOCK) begin
        case (b)
          ST_CLOCK: begin e.kind = KIND_TICK;  fire = clock_source; end
          ST_START: begin e.kind = KIND_START; fire = clock_source; end
          ST_STOP:  begin e.kind = KIND_STOP;  fire = clock_source; end
          ST_SENSE: begin e.kind = KIND_SENSE; fire = 1'b1; end
          default: ;
        endcase
      end else if (b[7]) begin
        running_status = b;
        data_count = '0;
        e.raw_byte = b;
        if (b == ST_SYSEX_START) begin
          e.kind = KIND_SYSEX_START;
          e.dropped_previous = sysex_open;
          sysex_open = 1'b1;
          fire = 1'b1;
        end else if (b == ST_SYSEX_END) begin
          running_status = '0;
          e.kind = KIND_SYSEX_END;
          fire = sysex_open;
          sysex_open = 1'b0;
        end else begin
          e.kind = KIND_SYSEX_ABORT;
          fire = sysex_open;
          sysex_open = 1'b0;
        end
      end else if (running_status[7] && running_status[6:4] != SYS_GROUP) begin
        cmd = running_status[7:4];
        len = (cmd == CMD_PROGRAM || cmd == CMD_PRESSURE) ? 2'd1 : 2'd2;
        if (data_count == 0 && len == 2) begin
          first_data = b[6:0];
          data_count = 2'd1;
        end else begin
          data_count = '0;
          if (len == 1) begin
            v0 = b[6:0];
            v1 = '0;
          end else begin
            v0 = first_data;
            v1 = b[6:0];
          end
          e.kind = KIND_VOICE;
          e.command = cmd;
          e.channel = running_status[3:0];
          fire = 1'b1;
          if (cmd == CMD_NOTE_ON && len == 2 && v1 == 0) begin
            e.command = CMD_NOTE_OFF;
            e.first_value = v0;
            e.second_value = note_off_velocity;
          end else if (cmd == CMD_PITCH_BEND) begin
            e.bend_value = {v1, v0};
          end else begin
            e.first_value = v0;
            e.second_value = v1;
          end
        end
      end else if (running_status == ST_SYSEX_START) begin
        e.kind = KIND_SYSEX_DATA;
        e.raw_byte = b;
        fire = sysex_open;
      end else if (running_status == ST_QFRAME) begin
        running_status = '0;
        e.kind = KIND_QFRAME;
        e.raw_byte = b;
        fire = timecode_source;
      end
      if (fire) pending_events.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_event(evt_t got);
      evt_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("command", 32'(want.command), 32'(got.command));
      compare_field("channel", 32'(want.channel), 32'(got.channel));
      compare_field("first_value", 32'(want.first_value), 32'(got.first_value));
      compare_field("second_value", 32'(want.second_value), 32'(got.second_value));
      compare_field("bend_value", 32'(want.bend_value), 32'(got.bend_value));
      compare_field("raw_byte", 32'(want.raw_byte), 32'(got.raw_byte));
      compare_field("dropped_previous", 32'(want.dropped_previous),
                    32'(got.dropped_previous));
    endfunction
  endclass

  event_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_event({out_kind, out_command, out_channel, out_first_value,
                        out_second_value, out_bend_value, out_raw_byte,
                        out_dropped_previous});
      end
      if (in_valid && !in_stall) sb.note_byte(in_data_byte);
    end
  end

  function automatic logic [6:0] data7();
    case ($urandom_range(3))
      0:       return 7'h00;
      1:       return 7'h7F;
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b);
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [6:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(bit enabled, bit clk_master, bit tc_master, logic [6:0] vel);
    cfg_write(CFG_INPUT_ENABLED, {6'd0, enabled});
    cfg_write(CFG_CLOCK_SOURCE, {6'd0, clk_master});
    cfg_write(CFG_TIMECODE_SOURCE, {6'd0, tc_master});
    cfg_write(CFG_NOTE_OFF_VELOCITY, vel);
    cfg_wr_en <= 1'b0;
  endtask

  // hold off until every event is out and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned target);
    int unsigned start_count;
    int unsigned pick;
    int unsigned n;
    logic [3:0]  cmd;
    start_count = bytes_sent;
    while (bytes_sent - start_count < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        cmd = 4'($urandom_range(CMD_NOTE_OFF, CMD_PITCH_BEND));
        if ($urandom_range(4) != 0) send_byte({cmd, 4'($urandom_range(15))});
        n = (cmd == CMD_PROGRAM || cmd == CMD_PRESSURE) ? 1 : 2;
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(9) == 0) send_byte(8'($urandom_range(ST_CLOCK, 8'hFF)));
          send_byte((i == 1 && $urandom_range(3) == 0) ? 8'h00 : {1'b0, data7()});
        end
      end else if (pick < 70) begin
        send_byte(ST_SYSEX_START);
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(9) == 0) send_byte(8'($urandom_range(ST_CLOCK, 8'hFF)));
          send_byte({1'b0, data7()});
        end
        case ($urandom_range(9))
          0, 1:    send_byte(8'($urandom_range(8'h80, 8'hF7)));
          2:       send_byte(ST_SYSEX_START);
          default: send_byte(ST_SYSEX_END);
        endcase
      end else if (pick < 78) begin
        send_byte(ST_QFRAME);
        send_byte({1'b0, data7()});
      end else if (pick < 88) begin
        send_byte(8'($urandom_range(ST_CLOCK, 8'hFF)));
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  logic [7:0] directed_bytes[] = '{
    8'h90, 8'h00, 8'h7F, 8'h00, 8'h00,
    8'hC5, 8'h7F,
    8'hEF, 8'h7F, 8'h7F,
    8'hF8, 8'hFA, 8'hFC, 8'hFE, 8'hF9,
    8'hF0, 8'h55, 8'hF0, 8'hF7,
    8'hF7,
    8'hF1, 8'h3A,
    8'h12,
    8'hF0, 8'h80
  };

  initial begin
    logic [6:0] vel;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    configure(1'b1, 1'b1, 1'b1, 7'h7F);
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      vel = (ph == 0) ? 7'h00 : (ph == 1) ? 7'h7F : 7'($urandom_range(127));
      if (ph == 4) begin
        configure(1'b0, 1'b1, 1'b1, vel);
        for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(255)));
        drain();
      end
      configure(1'b1, ph[0], ph[1], vel);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      run_phase(225);
      drain();
    end
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
